[rtl/pctu_pkg.sv]
// ----------------------------------------------------------------------------
// Packed color transform package
// Operation codes, packed color layout constants and the arithmetic helpers
// that the color datapath shares.
// ----------------------------------------------------------------------------
package pctu_pkg;

   typedef enum logic [2:0] {
      OP_LERP      = 3'd0,
      OP_BRIGHTEN  = 3'd1,
      OP_DARKEN    = 3'd2,
      OP_GRAYSCALE = 3'd3,
      OP_INVERT    = 3'd4
   } op_type;

   // Tag plus the ARGB bytes of one packed color word.
   typedef struct packed {
      logic       tag;
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   localparam int COLOR_WIDTH  = 64;
   localparam int RESULT_WIDTH = 57;
   localparam int AMOUNT_WIDTH = 16;
   localparam int TAG_BIT      = 56;

   localparam logic [7:0]  CHANNEL_MAX = 8'hFF;
   localparam logic [6:0]  PCT_MAX     = 7'd100;

   // Luma weights; the weighted sum is at most 255000 and fits in 18 bits.
   localparam logic [17:0] LUMA_RED   = 18'd299;
   localparam logic [17:0] LUMA_GREEN = 18'd587;
   localparam logic [17:0] LUMA_BLUE  = 18'd114;
   // ceil(2^28 / 1000): exact truncating division for sums below 2^18.
   localparam int          LUMA_SHIFT = 28;
   localparam logic [18:0] LUMA_RECIP = 19'd268436;

   // Percent coefficients ceil(pct * 2^16 / 100). Multiplying a byte by one
   // of these and dropping 16 bits gives the truncated quotient exactly.
   localparam int COEF_SHIFT = 16;
   typedef logic [16:0] coef_table_type [0:127];

   function automatic coef_table_type build_coef_table();
      coef_table_type t;
      for (int i = 0; i < 128; i++) begin
         if (i <= 100) begin
            t[i] = 17'((i * 65536 + 99) / 100);
         end else begin
            t[i] = '0;
         end
      end
      return t;
   endfunction

   localparam coef_table_type PCT_COEF = build_coef_table();

   // Moves a channel from its start value toward a target by a percentage,
   // truncating the step toward zero.
   function automatic logic [7:0] mix_lane(logic [7:0] from, logic [7:0] target,
                                           logic [16:0] coef);
      logic        up;
      logic [7:0]  mag;
      logic [24:0] prod;
      logic [7:0]  step;
      up   = (target >= from);
      mag  = up ? (target - from) : (from - target);
      prod = 25'(mag) * 25'(coef);
      step = prod[23:16];
      return up ? (from + step) : (from - step);
   endfunction

endpackage

[rtl/pctu_alu.sv]
// ----------------------------------------------------------------------------
// Packed color transform datapath
// Computes one packed result color from the registered operands in a single
// pass of combinational logic.
// ----------------------------------------------------------------------------
module pctu_alu (
   input  logic [2:0]                              operation,
   input  pctu_pkg::color_type                     color_first,
   input  pctu_pkg::color_type                     color_second,
   input  logic signed [pctu_pkg::AMOUNT_WIDTH-1:0] amount,
   output logic [pctu_pkg::RESULT_WIDTH-1:0]       color_result
);
   import pctu_pkg::*;

   logic [6:0]  pct;
   logic [16:0] coef;
   logic [7:0]  alpha_first;
   logic [7:0]  alpha_second;
   logic [7:0]  target_red;
   logic [7:0]  target_green;
   logic [7:0]  target_blue;
   logic [7:0]  mix_red;
   logic [7:0]  mix_green;
   logic [7:0]  mix_blue;
   logic [7:0]  mix_alpha;
   logic [17:0] luma_sum;
   logic [36:0] luma_prod;
   logic [7:0]  luma;
   logic [7:0]  res_red;
   logic [7:0]  res_green;
   logic [7:0]  res_blue;
   logic [7:0]  res_alpha;
   logic        res_tag;

   always_comb begin
      if (amount[AMOUNT_WIDTH-1]) begin
         pct = '0;
      end else if (amount > AMOUNT_WIDTH'(PCT_MAX)) begin
         pct = PCT_MAX;
      end else begin
         pct = amount[6:0];
      end
   end

   assign coef = PCT_COEF[pct];

   // An untagged color counts as fully opaque.
   assign alpha_first  = color_first.tag  ? color_first.alpha  : CHANNEL_MAX;
   assign alpha_second = color_second.tag ? color_second.alpha : CHANNEL_MAX;

   // Lerp, brighten and darken are all a move toward a target value.
   always_comb begin
      case (operation)
         OP_BRIGHTEN: begin
            target_red   = CHANNEL_MAX;
            target_green = CHANNEL_MAX;
            target_blue  = CHANNEL_MAX;
         end
         OP_DARKEN: begin
            target_red   = '0;
            target_green = '0;
            target_blue  = '0;
         end
         default: begin
            target_red   = color_second.red;
            target_green = color_second.green;
            target_blue  = color_second.blue;
         end
      endcase
   end

   assign mix_red   = mix_lane(color_first.red,   target_red,   coef);
   assign mix_green = mix_lane(color_first.green, target_green, coef);
   assign mix_blue  = mix_lane(color_first.blue,  target_blue,  coef);
   assign mix_alpha = mix_lane(alpha_first,       alpha_second, coef);

   assign luma_sum  = 18'(color_first.red)   * LUMA_RED
                    + 18'(color_first.green) * LUMA_GREEN
                    + 18'(color_first.blue)  * LUMA_BLUE;
   assign luma_prod = 37'(luma_sum) * 37'(LUMA_RECIP);
   assign luma      = luma_prod[LUMA_SHIFT+7:LUMA_SHIFT];

   always_comb begin
      res_alpha = alpha_first;
      res_tag   = color_first.tag;
      unique case (operation)
         OP_LERP: begin
            res_red   = mix_red;
            res_green = mix_green;
            res_blue  = mix_blue;
            res_alpha = mix_alpha;
            res_tag   = color_first.tag | color_second.tag;
         end
         OP_BRIGHTEN, OP_DARKEN: begin
            res_red   = mix_red;
            res_green = mix_green;
            res_blue  = mix_blue;
         end
         OP_GRAYSCALE: begin
            res_red   = luma;
            res_green = luma;
            res_blue  = luma;
         end
         OP_INVERT: begin
            res_red   = ~color_first.red;
            res_green = ~color_first.green;
            res_blue  = ~color_first.blue;
         end
         default: begin
            res_red   = color_first.red;
            res_green = color_first.green;
            res_blue  = color_first.blue;
         end
      endcase
   end

   // The alpha byte and the tag appear only on a tagged result.
   always_comb begin
      if (res_tag) begin
         color_result = {1'b1, 24'b0, res_alpha, res_red, res_green, res_blue};
      end else begin
         color_result = {33'b0, res_red, res_green, res_blue};
      end
   end

endmodule

[rtl/packed_color_transform_unit_core.sv]
// ----------------------------------------------------------------------------
// Packed color transform unit
// Applies lerp, brighten, darken, grayscale or invert to packed ARGB colors.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction on the req_ channel carries an operation code, one or two
//   packed colors and a signed percentage. Each one produces exactly one
//   packed color on the rsp_ channel, in order.
//   Both channels are valid/stall: a transaction moves on a rising edge where
//   valid is high and stall is low.
// Pipeline and throughput:
//   A request is registered on acceptance, the whole color computation runs
//   between that input register and the result register, and the result is
//   offered from the result register. One transaction is taken every cycle
//   while rsp_stall stays low.
// Stall behavior:
//   While rsp_stall is high and a result is offered, the result register holds
//   its value; the input register still takes one more request, and req_stall
//   rises only when both registers are full.
// Reset:
//   Synchronous reset empties both registers; no result is offered after it.
// ----------------------------------------------------------------------------
module packed_color_transform_unit_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [2:0]                               req_operation,
   input  logic [pctu_pkg::COLOR_WIDTH-1:0]         req_color_first,
   input  logic [pctu_pkg::COLOR_WIDTH-1:0]         req_color_second,
   input  logic signed [pctu_pkg::AMOUNT_WIDTH-1:0] req_amount,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [pctu_pkg::RESULT_WIDTH-1:0]        rsp_color_result
);
   import pctu_pkg::*;

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic [2:0]                     operation_ff;
   color_type                      color_first_ff;
   color_type                      color_second_ff;
   logic signed [AMOUNT_WIDTH-1:0] amount_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [RESULT_WIDTH-1:0]        color_result_ff;
   logic [RESULT_WIDTH-1:0]        color_result_in;
   logic                           out_ready;
   logic                           in_ready;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign in_ready  = !in_valid_ff || out_ready;
   assign req_stall = !in_ready;

   assign in_valid_in  = in_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = out_ready ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         operation_ff    <= req_operation;
         color_first_ff  <= {req_color_first[TAG_BIT], req_color_first[31:0]};
         color_second_ff <= {req_color_second[TAG_BIT], req_color_second[31:0]};
         amount_ff       <= req_amount;
      end
   end

   pctu_alu u_alu (
      .operation    (operation_ff),
      .color_first  (color_first_ff),
      .color_second (color_second_ff),
      .amount       (amount_ff),
      .color_result (color_result_in)
   );

   always_ff @(posedge clock) begin
      if (out_ready && in_valid_ff) begin
         color_result_ff <= color_result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_color_result = color_result_ff;

endmodule

[dv/pctu_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed color transform result checker
// Watches both channels of the packed color transform unit, computes the
// color each accepted request should produce and compares it with the
// results as they are taken, oldest first.
// ----------------------------------------------------------------------------
module pctu_result_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  logic [2:0]                               req_operation,
   input  logic [pctu_pkg::COLOR_WIDTH-1:0]         req_color_first,
   input  logic [pctu_pkg::COLOR_WIDTH-1:0]         req_color_second,
   input  logic signed [pctu_pkg::AMOUNT_WIDTH-1:0] req_amount,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic [pctu_pkg::RESULT_WIDTH-1:0]        rsp_color_result,
   output int                                       fail_count,
   output int                                       outstanding
);
   import pctu_pkg::*;

   logic [RESULT_WIDTH-1:0] expected_colors[$];

   function automatic logic [7:0] clamp_byte(int v);
      if (v < 0) begin
         return 8'd0;
      end
      if (v > 255) begin
         return 8'd255;
      end
      return 8'(v);
   endfunction

   function automatic int alpha_or_opaque(logic [COLOR_WIDTH-1:0] c);
      return c[TAG_BIT] ? int'(c[31:24]) : 255;
   endfunction

   function automatic logic [RESULT_WIDTH-1:0] transform_color(
      logic [2:0]                     op,
      logic [COLOR_WIDTH-1:0]         c1,
      logic [COLOR_WIDTH-1:0]         c2,
      logic signed [AMOUNT_WIDTH-1:0] amt
   );
      int                      pct;
      int                      r, g, b, a, y;
      logic                    has_tag;
      logic [RESULT_WIDTH-1:0] res;
      pct = amt;
      if (pct < 0) begin
         pct = 0;
      end
      if (pct > 100) begin
         pct = 100;
      end
      r       = int'(c1[23:16]);
      g       = int'(c1[15:8]);
      b       = int'(c1[7:0]);
      a       = alpha_or_opaque(c1);
      has_tag = c1[TAG_BIT];
      case (op)
         OP_LERP: begin
            // An untagged endpoint still blends in with an opaque alpha.
            r       = r + ((int'(c2[23:16]) - r) * pct) / 100;
            g       = g + ((int'(c2[15:8]) - g) * pct) / 100;
            b       = b + ((int'(c2[7:0]) - b) * pct) / 100;
            a       = a + ((alpha_or_opaque(c2) - a) * pct) / 100;
            has_tag = has_tag | c2[TAG_BIT];
         end
         OP_BRIGHTEN: begin
            r = r + ((255 - r) * pct) / 100;
            g = g + ((255 - g) * pct) / 100;
            b = b + ((255 - b) * pct) / 100;
         end
         OP_DARKEN: begin
            r = r - (r * pct) / 100;
            g = g - (g * pct) / 100;
            b = b - (b * pct) / 100;
         end
         OP_GRAYSCALE: begin
            y = (r * 299 + g * 587 + b * 114) / 1000;
            r = y;
            g = y;
            b = y;
         end
         OP_INVERT: begin
            r = 255 - r;
            g = 255 - g;
            b = 255 - b;
         end
         default: begin
            // Unassigned codes pass the first color through.
         end
      endcase
      res        = '0;
      res[23:16] = clamp_byte(r);
      res[15:8]  = clamp_byte(g);
      res[7:0]   = clamp_byte(b);
      if (has_tag) begin
         res[31:24]   = clamp_byte(a);
         res[TAG_BIT] = 1'b1;
      end
      return res;
   endfunction

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // Sampled at the rising edge, so every value seen is the one the block saw.
   always @(posedge clock) begin
      logic [RESULT_WIDTH-1:0] want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_colors.size() == 0) begin
               $error("color_result: transaction with none outstanding, actual %h",
                      rsp_color_result);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_colors.pop_front();
               if (rsp_color_result !== want) begin
                  $error("color_result mismatch: expected %h, actual %h",
                         want, rsp_color_result);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_colors.push_back(transform_color(req_operation, req_color_first,
                                                      req_color_second, req_amount));
         end
      end
      outstanding <= expected_colors.size();
   end

endmodule

[dv/packed_color_transform_unit_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed color transform unit testbench
// Drives directed corner colors and then random colors, operations and
// percentages through the block with random gaps and result stalls, while a
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module packed_color_transform_unit_core_tb;
   import pctu_pkg::*;

   localparam int RANDOM_ITEMS = 630;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [2:0]                     req_operation;
   logic [COLOR_WIDTH-1:0]         req_color_first;
   logic [COLOR_WIDTH-1:0]         req_color_second;
   logic signed [AMOUNT_WIDTH-1:0] req_amount;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [RESULT_WIDTH-1:0]        rsp_color_result;
   logic                           calm = 1'b0;
   int                             fail_count;
   int                             outstanding;

   always #6 clock = ~clock;

   packed_color_transform_unit_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_color_first  (req_color_first),
      .req_color_second (req_color_second),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_color_result (rsp_color_result)
   );

   pctu_result_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_color_first  (req_color_first),
      .req_color_second (req_color_second),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_color_result (rsp_color_result),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 37);
   end

   task automatic send_color(input logic [2:0]                     op,
                             input logic [COLOR_WIDTH-1:0]         c1,
                             input logic [COLOR_WIDTH-1:0]         c2,
                             input logic signed [AMOUNT_WIDTH-1:0] amt);
      while (!calm && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_color_first  <= c1;
      req_color_second <= c2;
      req_amount       <= amt;
      do @(posedge clock); while (req_stall);
   endtask

   // Holds the request side idle until every result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      logic [COLOR_WIDTH-1:0]         c1, c2;
      logic signed [AMOUNT_WIDTH-1:0] amt;
      logic [2:0]                     op;
      int                             pick;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_operation    <= '0;
      req_color_first  <= '0;
      req_color_second <= '0;
      req_amount       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Lerp at the ends of the color range and of the percentage range.
      send_color(OP_LERP, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'sd100);
      send_color(OP_LERP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 16'sd0);
      send_color(OP_LERP, 64'h0100_0000_8040_20FF, 64'h0000_0000_10F0_0001, 16'sd50);
      send_color(OP_LERP, 64'h0000_0000_10F0_0001, 64'h0100_0000_0040_20FF, -16'sd32768);
      send_color(OP_LERP, 64'h00AA_5500_1122_3344, 64'h0100_0000_F0E0_D0C0, 16'sd32767);
      send_color(OP_LERP, 64'h0100_0000_FF00_FF00, 64'h0100_0000_00FF_00FF, 16'sd101);
      send_color(OP_LERP, 64'h0100_0000_FF00_FF00, 64'h0100_0000_00FF_00FF, -16'sd1);
      send_color(OP_LERP, 64'h0100_0000_FF00_FF00, 64'h0100_0000_00FF_00FF, 16'sd99);
      // The second color, tag included, is ignored outside lerp.
      send_color(OP_BRIGHTEN, 64'h0000_0000_0080_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 16'sd37);
      send_color(OP_BRIGHTEN, 64'h0100_0000_7F01_80FE, 64'h0, 16'sd200);
      send_color(OP_DARKEN, 64'h0100_0000_FFFF_FFFF, 64'h0, 16'sd99);
      send_color(OP_DARKEN, 64'h0000_0000_C864_0A01, 64'h0, -16'sd5);
      send_color(OP_GRAYSCALE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 16'sd0);
      send_color(OP_GRAYSCALE, 64'h0100_0000_7F3A_9C12, 64'h0, 16'sd0);
      send_color(OP_GRAYSCALE, 64'h0000_0000_0000_0000, 64'h0, 16'sd0);
      send_color(OP_INVERT, 64'h0, 64'h0100_0000_0000_0000, 16'sd0);
      send_color(OP_INVERT, 64'hFEFF_FFFF_1234_5678, 64'h0, 16'sd0);
      for (int k = OP_INVERT + 1; k < 8; k++) begin
         send_color(3'(k), 64'hFFFF_FFFF_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF, 16'sd50);
      end
      send_color(3'(OP_INVERT + 1), 64'hFEFF_FFFF_89AB_CDEF, 64'h0, 16'sd50);

      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm <= (i >= 200) && (i < 330);
         if (i == 450) begin
            drain_results();
         end
         pick = $urandom_range(19);
         op   = (pick < 17) ? 3'(pick % 5) : 3'($urandom_range(7));
         c1   = {$urandom, $urandom};
         c2   = {$urandom, $urandom};
         case ($urandom_range(7))
            0: c1[23:0] = 24'hFFFFFF;
            1: c1[23:0] = 24'h000000;
            default: ;
         endcase
         amt = ($urandom_range(3) == 0) ? AMOUNT_WIDTH'($urandom)
                                        : AMOUNT_WIDTH'($urandom_range(100));
         send_color(op, c1, c2, amt);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS packed_color_transform_unit_core");
      end else begin
         $display("FAIL packed_color_transform_unit_core");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL packed_color_transform_unit_core");
      $finish;
   end

endmodule
